>>> rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/bpq_pkg.sv
`timescale 1ns / 1ps

package bpq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_REMOVE    = 2'd1,
		OP_POP_FIRST = 2'd2,
		OP_POP_LAST  = 2'd3
	} bpq_op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_QUEUED     = 2'd2,
		ST_NOT_QUEUED = 2'd3
	} bpq_status_t;

	// commands to the occupancy bitmap
	typedef struct packed {
		logic set;
		logic clr;
		logic find_grp;
		logic find_bit;
	} bpq_occ_cmd_t;

endpackage

>>> rtl/core/bucket_priority_queue_core.sv
`timescale 1ns / 1ps

// Bucket priority queue over node numbers 0..NODE_COUNT-1, keys 0..KEY_COUNT-1.
// Command channel: an operation transfers at a rising edge with start high and
// busy low; operation, node_id and key are sampled then. Operations are
// insert, remove, pop first (newest node of the smallest key) and pop last
// (oldest node of the smallest key).
// Result channel: exactly one result per operation, shown for one cycle with
// done high; the receiver cannot stall, so nothing waits on it.
// A new command may transfer in the cycle that done is high.
// A remove reads the node and unlinks it; an insert also clears the new
// node's back link; a pop runs the two encoder passes, reads the bucket, then
// the chosen node. A rejected insert or remove, and a pop on an empty queue,
// end after the first step. The length of an operation is set by the dependent
// reads of the link memories and the two passes of the shared priority encoder
// over the bucket bitmap. After reset the node flags are swept clear, one node a
// cycle, and busy stays high until every node is clear, before any command.

module bucket_priority_queue_core
	import bpq_pkg::*;
#(
	parameter int NODE_COUNT = 1024,
	parameter int KEY_COUNT  = 256,
	localparam int NW = $clog2(NODE_COUNT),
	localparam int KW = $clog2(KEY_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    operation,
	input  logic [NW-1:0] node_id,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [1:0]    status,
	output logic          found,
	output logic [NW-1:0] popped_node,
	output logic [KW-1:0] popped_key
);

	localparam int LW = $clog2(NODE_COUNT + 1);
	localparam int NW1 = NW + 1;
	localparam int KW1 = KW + 1;
	localparam logic [LW-1:0] LINK_NONE = LW'(NODE_COUNT);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_INS,
		S_SCAN,
		S_BKT,
		S_SEL,
		S_UNL
	} state_t;

	// memories
	logic [LW-1:0] next_mem [NODE_COUNT];
	logic [LW-1:0] prev_mem [NODE_COUNT];
	logic [KW:0]   meta_mem [NODE_COUNT];
	logic [NW-1:0] head_mem [KEY_COUNT];
	logic [NW-1:0] tail_mem [KEY_COUNT];

	state_t        state_q;
	logic [NW-1:0] clr_q;
	bpq_op_t       op_q;
	logic [NW-1:0] sel_q;
	logic [KW-1:0] key_q;
	logic          done_q;
	bpq_status_t   status_q;
	logic          found_q;
	logic [NW-1:0] pnode_q;
	logic [KW-1:0] pkey_q;

	logic [LW-1:0] next_rd_q, prev_rd_q;
	logic [KW:0]   meta_rd_q;
	logic [NW-1:0] head_rd_q, tail_rd_q;

	logic          next_we, prev_we, meta_we, head_we, tail_we;
	logic [NW-1:0] next_wa, prev_wa, meta_wa;
	logic [KW-1:0] head_wa, tail_wa;
	logic [LW-1:0] next_wd, prev_wd;
	logic [KW:0]   meta_wd;
	logic [NW-1:0] head_wd, tail_wd;
	logic [NW-1:0] node_ra;
	logic [KW-1:0] bkt_ra;

	logic [NW:0]   nd_ext;
	logic [KW:0]   key_ext;
	logic [NW-1:0] nd_in;
	logic [KW-1:0] key_in;
	bpq_op_t       op_in;
	logic          accept;
	logic          in_pop;
	logic [NW-1:0] sel_w;
	logic          queued;
	logic [KW-1:0] mkey;
	logic          nx_ok, pv_ok;
	logic          ins_en, unl_en;

	bpq_occ_cmd_t  occ_cmd;
	logic [KW-1:0] occ_wr_idx;
	logic          occ_bit;
	logic          occ_any;
	logic [KW-1:0] occ_min;

	bpq_occ #(
		.KEY_COUNT(KEY_COUNT)
	) u_occ (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (occ_cmd),
		.wr_idx (occ_wr_idx),
		.rd_idx (key_q),
		.rd_bit (occ_bit),
		.any    (occ_any),
		.min_idx(occ_min)
	);

	// inputs reduced into range
	assign nd_ext  = {1'b0, node_id};
	assign key_ext = {1'b0, key};
	assign nd_in   = (nd_ext >= NW1'(NODE_COUNT)) ? NW'(nd_ext - NW1'(NODE_COUNT)) : node_id;
	assign key_in  = (key_ext >= KW1'(KEY_COUNT)) ? KW'(key_ext - KW1'(KEY_COUNT)) : key;
	assign op_in   = bpq_op_t'(operation);
	assign in_pop  = (op_in == OP_POP_FIRST) || (op_in == OP_POP_LAST);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign sel_w  = (op_q == OP_POP_FIRST) ? head_rd_q : tail_rd_q;
	assign queued = meta_rd_q[KW];
	assign mkey   = meta_rd_q[KW-1:0];
	assign nx_ok  = (next_rd_q != LINK_NONE);
	assign pv_ok  = (prev_rd_q != LINK_NONE);

	assign ins_en = (state_q == S_LOOK) && (op_q == OP_INSERT) && !queued;
	assign unl_en = ((state_q == S_LOOK) && (op_q == OP_REMOVE) && queued)
		|| (state_q == S_UNL);

	always_comb begin
		node_ra = sel_q;
		if (state_q == S_IDLE) begin
			node_ra = nd_in;
		end else if (state_q == S_SEL) begin
			node_ra = sel_w;
		end
		bkt_ra = key_q;
		if (state_q == S_IDLE) begin
			bkt_ra = key_in;
		end else if (state_q == S_BKT) begin
			bkt_ra = occ_min;
		end
	end

	// link and bucket updates
	always_comb begin
		next_we = 1'b0;
		next_wa = sel_q;
		next_wd = LINK_NONE;
		prev_we = 1'b0;
		prev_wa = sel_q;
		prev_wd = LINK_NONE;
		meta_we = 1'b0;
		meta_wa = sel_q;
		meta_wd = '0;
		head_we = 1'b0;
		head_wa = key_q;
		head_wd = sel_q;
		tail_we = 1'b0;
		tail_wa = key_q;
		tail_wd = sel_q;
		occ_cmd = '0;
		occ_wr_idx = key_q;
		occ_cmd.find_grp = accept && in_pop;
		occ_cmd.find_bit = (state_q == S_SCAN);
		if (state_q == S_CLEAR) begin
			meta_we = 1'b1;
			meta_wa = clr_q;
		end
		if (ins_en) begin
			next_we = 1'b1;
			next_wd = occ_bit ? LW'(head_rd_q) : LINK_NONE;
			prev_we = occ_bit;
			prev_wa = head_rd_q;
			prev_wd = LW'(sel_q);
			head_we = 1'b1;
			tail_we = !occ_bit;
			meta_we = 1'b1;
			meta_wd = {1'b1, key_q};
			occ_cmd.set = 1'b1;
		end
		if (state_q == S_INS) begin
			prev_we = 1'b1;
		end
		if (unl_en) begin
			occ_wr_idx = mkey;
			head_wa = mkey;
			tail_wa = mkey;
			if (nx_ok) begin
				prev_we = 1'b1;
				prev_wa = next_rd_q[NW-1:0];
				prev_wd = prev_rd_q;
			end else begin
				tail_we = 1'b1;
				tail_wd = prev_rd_q[NW-1:0];
			end
			if (pv_ok) begin
				next_we = 1'b1;
				next_wa = prev_rd_q[NW-1:0];
				next_wd = next_rd_q;
			end else if (nx_ok) begin
				head_we = 1'b1;
				head_wd = next_rd_q[NW-1:0];
			end else begin
				occ_cmd.clr = 1'b1;
			end
			meta_we = 1'b1;
			meta_wd = {1'b0, mkey};
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		meta_rd_q <= meta_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd_q <= head_mem[bkt_ra];
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_mem[tail_wa] <= tail_wd;
		end
		tail_rd_q <= tail_mem[bkt_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			op_q     <= OP_INSERT;
			sel_q    <= '0;
			key_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
			found_q  <= 1'b0;
			pnode_q  <= '0;
			pkey_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NW'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op_in;
						sel_q   <= nd_in;
						key_q   <= key_in;
						state_q <= in_pop ? S_SCAN : S_LOOK;
					end
				end
				S_LOOK: begin
					if (op_q == OP_INSERT && !queued) begin
						state_q <= S_INS;
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						found_q  <= 1'b0;
						pnode_q  <= '0;
						pkey_q   <= '0;
						if (op_q == OP_INSERT) begin
							status_q <= ST_QUEUED;
						end else if (!queued) begin
							status_q <= ST_NOT_QUEUED;
						end else begin
							status_q <= ST_DONE;
						end
					end
				end
				S_INS: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_DONE;
					found_q  <= 1'b0;
					pnode_q  <= '0;
					pkey_q   <= '0;
				end
				S_SCAN: begin
					if (occ_any) begin
						state_q <= S_BKT;
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_EMPTY;
						found_q  <= 1'b0;
						pnode_q  <= '0;
						pkey_q   <= '0;
					end
				end
				S_BKT: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					sel_q   <= sel_w;
					state_q <= S_UNL;
				end
				S_UNL: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_DONE;
					found_q  <= 1'b1;
					pnode_q  <= sel_q;
					pkey_q   <= occ_min;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign popped_node = pnode_q;
	assign popped_key  = pkey_q;

endmodule

>>> rtl/core/bpq_occ.sv
`timescale 1ns / 1ps

module bpq_occ
	import bpq_pkg::*;
#(
	parameter int KEY_COUNT = 256,
	localparam int KW = $clog2(KEY_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bpq_occ_cmd_t  cmd,
	input  logic [KW-1:0] wr_idx,
	input  logic [KW-1:0] rd_idx,
	output logic          rd_bit,
	output logic          any,
	output logic [KW-1:0] min_idx
);

	localparam int KWP = (KW < 2) ? 2 : KW;
	localparam int LB  = KWP / 2;
	localparam int HB  = KWP - LB;
	localparam int GS  = 1 << LB;
	localparam int NG  = 1 << HB;

	logic [NG-1:0][GS-1:0] occ_q;
	logic                  any_q;
	logic [HB-1:0]         grp_q;
	logic [KWP-1:0]        min_q;

	logic [KWP-1:0] widx;
	logic [KWP-1:0] ridx;
	logic [NG-1:0]  summary;
	logic [NG-1:0]  enc_in;
	logic [HB-1:0]  enc_idx;
	logic           enc_any;

	assign widx = KWP'(wr_idx);
	assign ridx = KWP'(rd_idx);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			summary[g] = |occ_q[g];
		end
	end

	// one priority encoder, used for the group summary and then for the group word
	assign enc_in = cmd.find_grp ? summary : NG'(occ_q[grp_q]);

	always_comb begin
		enc_idx = '0;
		enc_any = |enc_in;
		for (int i = NG - 1; i >= 0; i--) begin
			if (enc_in[i]) begin
				enc_idx = HB'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			any_q <= 1'b0;
			grp_q <= '0;
			min_q <= '0;
		end else begin
			if (cmd.set) begin
				occ_q[widx[KWP-1:LB]][widx[LB-1:0]] <= 1'b1;
			end
			if (cmd.clr) begin
				occ_q[widx[KWP-1:LB]][widx[LB-1:0]] <= 1'b0;
			end
			if (cmd.find_grp) begin
				any_q <= enc_any;
				grp_q <= enc_idx;
			end
			if (cmd.find_bit) begin
				min_q <= {grp_q, enc_idx[LB-1:0]};
			end
		end
	end

	assign rd_bit  = occ_q[ridx[KWP-1:LB]][ridx[LB-1:0]];
	assign any     = any_q;
	assign min_idx = min_q[KW-1:0];

endmodule

>>> rtl/core/bpq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpq_checker
	import bpq_pkg::*;
#(
	parameter int NODE_COUNT = 1024,
	parameter int KEY_COUNT  = 256,
	localparam int NW = $clog2(NODE_COUNT),
	localparam int KW = $clog2(KEY_COUNT)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic [1:0]    status,
	input logic          found,
	input logic [NW-1:0] popped_node,
	input logic [KW-1:0] popped_key
);

	// a result is only shown once the sequencer is free again
	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, done, !busy)

	// results never come back to back
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)

	// a command transfer always occupies the sequencer
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)

	// a returned node always comes with a plain success status
	`ASSERT_IMPLIES(a_found_ok, clk, arst_n, done && found, status == ST_DONE)

	// results without a node carry zero payload
	`ASSERT_IMPLIES(a_no_node_zero, clk, arst_n, done && !found,
		popped_node == '0 && popped_key == '0)

endmodule

bind bucket_priority_queue_core bpq_checker #(
	.NODE_COUNT(NODE_COUNT),
	.KEY_COUNT (KEY_COUNT)
) u_bpq_checker (.*);
